// File: rtl/led3_pkg.sv
// Shared constants and types for the LED three-bit symbol packer.
// No dependencies; compiled first.
package led3_pkg;

   localparam int WORD_BITS       = 32;   // serializer word width
   localparam int COLOR_BITS      = 24;   // green:red:blue
   localparam int SYM_BITS        = 3;    // line symbol per color bit
   localparam int LED_SYMBOL_BITS = COLOR_BITS * SYM_BITS;      // 72
   localparam int BUF_BITS        = WORD_BITS + LED_SYMBOL_BITS;
   localparam int FILL_BITS       = $clog2(WORD_BITS);
   localparam int REM_BITS        = $clog2(BUF_BITS);
   localparam int BRIGHT_BITS     = 9;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

   localparam logic [SYM_BITS-1:0]    SYM_ONE    = 3'b110;
   localparam logic [SYM_BITS-1:0]    SYM_ZERO   = 3'b100;
   localparam logic [BRIGHT_BITS-1:0] FULL_SCALE = 9'd256;

   // One encoded LED waiting for the packer.
   typedef struct packed {
      logic [LED_SYMBOL_BITS-1:0] symbols;
      logic                       eof;
   } led_item_type;

   // Packer status for checks at the top level.
   typedef struct packed {
      logic                 active;
      logic                 eof;
      logic [REM_BITS-1:0]  rem;
      logic [FILL_BITS-1:0] fill;
      logic                 flush_step;
   } pack_status_type;

endpackage

// File: rtl/led3_intf.sv
// Valid/ready channel interfaces for the LED three-bit symbol packer.
// Depends on led3_pkg for field widths.
interface led3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       end_of_frame;
   modport source (output valid, red, green, blue, end_of_frame, input ready);
   modport sink   (input valid, red, green, blue, end_of_frame, output ready);
endinterface

interface led3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] serial_word;
   logic        last_of_item;
   logic        frame_done;
   modport source (output valid, serial_word, last_of_item, frame_done, input ready);
   modport sink   (input valid, serial_word, last_of_item, frame_done, output ready);
endinterface

interface led3_csr_if;
   logic       valid;
   logic       ready;
   logic [led3_pkg::BRIGHT_BITS-1:0] brightness_q8;
   modport source (output valid, brightness_q8, input ready);
   modport sink   (input valid, brightness_q8, output ready);
endinterface

// File: rtl/led3_encoder.sv
// Front end: scales one LED color by brightness and expands it to 72 symbol bits.
// Depends on led3_pkg and led3_req_if.
module led3_encoder (
   led3_req_if.sink                          req_chan,
   input  logic [led3_pkg::BRIGHT_BITS-1:0]  bright,
   output logic                              push_valid,
   input  logic                              push_ready,
   output led3_pkg::led_item_type            push_item
);
   import led3_pkg::*;

   logic [BRIGHT_BITS-1:0] bright_clamped;
   logic [7:0]             red_s;
   logic [7:0]             green_s;
   logic [7:0]             blue_s;
   logic [COLOR_BITS-1:0]  color;

   // (byte * scale) >> 8; scale never above 256, so result fits a byte
   function automatic logic [7:0] scale_byte(input logic [7:0] v,
                                             input logic [BRIGHT_BITS-1:0] s);
      logic [16:0] prod;
      prod = 17'(v) * 17'(s);
      return prod[15:8];
   endfunction

   always_comb begin
      bright_clamped = (bright > FULL_SCALE) ? FULL_SCALE : bright;
      red_s   = scale_byte(req_chan.red,   bright_clamped);
      green_s = scale_byte(req_chan.green, bright_clamped);
      blue_s  = scale_byte(req_chan.blue,  bright_clamped);
      color   = {green_s, red_s, blue_s};
      for (int i = 0; i < COLOR_BITS; i++) begin
         push_item.symbols[i*SYM_BITS +: SYM_BITS] = color[i] ? SYM_ONE : SYM_ZERO;
      end
      push_item.eof = req_chan.end_of_frame;
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

// File: rtl/led3_queue.sv
// Small FIFO decoupling the encoder from the packer.
// Depends on led3_pkg.
module led3_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  led3_pkg::led_item_type  push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output led3_pkg::led_item_type  pop_item
);
   import led3_pkg::*;

   led_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS:0]   wr_ptr_ff;
   logic [QPTR_BITS:0]   rd_ptr_ff;
   logic                 do_push;
   logic                 do_pop;

   assign pop_valid  = (wr_ptr_ff != rd_ptr_ff);
   assign push_ready = !((wr_ptr_ff[QPTR_BITS] != rd_ptr_ff[QPTR_BITS]) &&
                         (wr_ptr_ff[QPTR_BITS-1:0] == rd_ptr_ff[QPTR_BITS-1:0]));
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff[QPTR_BITS-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff[QPTR_BITS-1:0]] <= push_item;
   end

endmodule

// File: rtl/led3_packer.sv
// Back end: packs symbol bits into 32-bit words, one word per cycle unless rsp_chan stalls, with flush.
// Depends on led3_pkg and led3_rsp_if.
module led3_packer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  led3_pkg::led_item_type    pop_item,
   led3_rsp_if.source                rsp_chan,
   output led3_pkg::pack_status_type status
);
   import led3_pkg::*;

   // control
   logic                  active_ff;
   logic                  rsp_valid_ff;
   logic [WORD_BITS-1:0]  part_ff;      // pending bits, left aligned, zero below
   logic [FILL_BITS-1:0]  fill_ff;
   // payload
   logic [BUF_BITS-1:0]   buf_ff;       // bits of current item, left aligned
   logic [REM_BITS-1:0]   rem_ff;
   logic                  eof_ff;
   logic [WORD_BITS-1:0]  word_ff;
   logic                  last_ff;
   logic                  done_ff;

   logic                  out_free;
   logic                  step;
   logic                  rem_ge;
   logic [REM_BITS-1:0]   rem_after;
   logic [BUF_BITS-1:0]   buf_shift;
   logic                  word_last;
   logic                  finish;
   logic [WORD_BITS-1:0]  part_in;
   logic [FILL_BITS-1:0]  fill_in;
   logic                  load;
   logic [BUF_BITS-1:0]   buf_in;
   logic [REM_BITS-1:0]   rem_in;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      step      = active_ff && out_free;
      rem_ge    = (rem_ff >= REM_BITS'(WORD_BITS));
      rem_after = rem_ge ? (rem_ff - REM_BITS'(WORD_BITS)) : '0;
      buf_shift = buf_ff << WORD_BITS;
      // a short remainder only survives when it is a flush pad
      word_last = !rem_ge ||
                  ((rem_after < REM_BITS'(WORD_BITS)) && !(eof_ff && (rem_after != '0)));
      finish    = step && word_last;

      part_in = part_ff;
      fill_in = fill_ff;
      if (finish) begin
         part_in = eof_ff ? '0 : buf_shift[BUF_BITS-1 -: WORD_BITS];
         fill_in = eof_ff ? '0 : rem_after[FILL_BITS-1:0];
      end

      load   = (!active_ff || finish) && pop_valid;
      buf_in = buf_shift;
      rem_in = rem_after;
      if (load) begin
         buf_in = {part_in, {LED_SYMBOL_BITS{1'b0}}} |
                  ({pop_item.symbols, {WORD_BITS{1'b0}}} >> fill_in);
         rem_in = REM_BITS'(fill_in) + REM_BITS'(LED_SYMBOL_BITS);
      end
   end

   assign pop_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         part_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         part_ff <= part_in;
         fill_ff <= fill_in;
         if (load)        active_ff <= 1'b1;
         else if (finish) active_ff <= 1'b0;
         if (step)                rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load || step) begin
         buf_ff <= buf_in;
         rem_ff <= rem_in;
      end
      if (load) eof_ff <= pop_item.eof;
      if (step) begin
         word_ff <= buf_ff[BUF_BITS-1 -: WORD_BITS];
         last_ff <= word_last;
         done_ff <= word_last && eof_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.serial_word  = word_ff;
   assign rsp_chan.last_of_item = last_ff;
   assign rsp_chan.frame_done   = done_ff;

   assign status.active     = active_ff;
   assign status.eof        = eof_ff;
   assign status.rem        = rem_ff;
   assign status.fill       = fill_ff;
   assign status.flush_step = finish && eof_ff;

endmodule

// File: rtl/led_three_bit_symbol_packer.sv
// Top level of the LED three-bit symbol packer.
// Depends on led3_pkg, led3_intf, led3_encoder, led3_queue, led3_packer.
//
// Usage:
//   req_chan  - one LED per transaction: red, green, blue bytes and
//               end_of_frame. Accepted when valid and ready are high.
//   rsp_chan  - one 32-bit serializer word per transaction, first line
//               bit in bit 31. last_of_item marks the final word of an
//               LED; frame_done marks the word that closes a frame.
//   csr_chan  - writes brightness_q8 (Q1.8, 256 = full, higher clamps).
//               Always ready. Write only while the block is idle.
// Each LED becomes 72 line bits (110 = one, 100 = zero, GRB, MSB first),
// packed across LED boundaries. end_of_frame zero-pads and emits any
// partial word and restarts packing at bit 31.
// When the queue is empty, the first word of an LED passes the queue
// write at acceptance, the packer load and the output register.
// The packer emits one word per cycle while rsp_chan is ready; the
// 2-entry queue keeps the front taking LEDs while the packer works.
// Reset: packing phase cleared, queue empty, brightness set to 256.
// Stall on rsp_chan: output word holds, packer stops, queue fills and
// then req_chan.ready drops.
module led_three_bit_symbol_packer (
   input  logic         clock,
   input  logic         reset,
   led3_req_if.sink     req_chan,
   led3_rsp_if.source   rsp_chan,
   led3_csr_if.sink     csr_chan
);
   import led3_pkg::*;

   logic [BRIGHT_BITS-1:0] brightness_ff;
   logic                   push_valid;
   logic                   push_ready;
   led_item_type           push_item;
   logic                   pop_valid;
   logic                   pop_ready;
   led_item_type           pop_item;
   pack_status_type        pack_status;

   // brightness register; the port never stalls
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= FULL_SCALE;
      end else if (csr_chan.valid) begin
         brightness_ff <= csr_chan.brightness_q8;
      end
   end

   // front: scale and expand to symbols
   led3_encoder u_encoder (
      .req_chan   (req_chan),
      .bright     (brightness_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decoupling queue
   led3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back: word packing and output register
   led3_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan),
      .status    (pack_status)
   );

   // a frame-closing word always ends its LED
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_done |-> rsp_chan.last_of_item)
      else $error("frame_done without last_of_item");

   // a flush leaves the packing phase at zero
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      pack_status.flush_step |=> (pack_status.fill == '0))
      else $error("fill not cleared after flush");

   // less than a word left in an active item only as a flush pad
   a_short_rem: assert property (@(posedge clock) disable iff (reset)
      pack_status.active && (pack_status.rem < REM_BITS'(WORD_BITS))
      |-> pack_status.eof && (pack_status.rem != '0))
      else $error("short remainder outside a flush");

endmodule
